[rtl/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared constants, types and the control struct of the point sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 18;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_KEY,
    ST_SCAN,
    ST_PLACE,
    ST_RD,
    ST_LD,
    ST_SEND
  } state_t;

  // Control of the rank counter for one comparison cycle.
  typedef struct packed {
    logic clear;
    logic en;
    logic earlier;
  } rank_ctl_t;

endpackage

`default_nettype wire

[rtl/pls_if.sv]
// ----------------------------------------------------------------------------
// pls_if
// Valid/ready channels that carry input points and sorted points.
// ----------------------------------------------------------------------------
`default_nettype none

interface pls_in_if
  import pls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

interface pls_out_if
  import pls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] sorted_x;
  logic signed [COORD_BITS-1:0] sorted_y;
  logic                         final_result;

  modport source (output valid, sorted_x, sorted_y, final_result, input ready);
  modport sink   (input valid, sorted_x, sorted_y, final_result, output ready);
endinterface

`default_nettype wire

[rtl/pls_mem.sv]
// ----------------------------------------------------------------------------
// pls_mem
// Single write port, single read port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_mem
  import pls_pkg::*;
#(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int WIDTH = 2 * COORD_BITS_DEF,
  localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [ABITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [ABITS-1:0] rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/pls_rank_unit.sv]
// ----------------------------------------------------------------------------
// pls_rank_unit
// Counts how many stored points come before the key point in sorted order.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_rank_unit
  import pls_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_BITS = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rank_ctl_t                    ctl,
  input  wire logic signed [COORD_BITS-1:0] key_x,
  input  wire logic signed [COORD_BITS-1:0] key_y,
  input  wire logic signed [COORD_BITS-1:0] cand_x,
  input  wire logic signed [COORD_BITS-1:0] cand_y,
  output logic             [IDX_BITS-1:0]   rank
);

  logic x_less;
  logic x_eq;
  logic y_less;
  logic y_eq;
  logic ahead;

  assign x_less = cand_x < key_x;
  assign x_eq   = cand_x == key_x;
  assign y_less = cand_y < key_y;
  assign y_eq   = cand_y == key_y;

  // Equal points are ranked by store position so that every rank is unique.
  assign ahead = x_less || (x_eq && y_less) || (x_eq && y_eq && ctl.earlier);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      rank <= '0;
    end else if (ctl.en && ahead) begin
      rank <= rank + IDX_BITS'(1);
    end
  end

endmodule

`default_nettype wire

[rtl/point_lexicographic_sorter_unit.sv]
// ----------------------------------------------------------------------------
// point_lexicographic_sorter_unit
// Loads a set of points and emits them ordered by x, then by y.
// ----------------------------------------------------------------------------
// Loading takes one cycle per point; the final point starts the sort.
// Sorting ranks each point by one scan of the point store, one store read per
// cycle, then writes the point to the order store. Each sorted word is then
// read, registered and held valid until the receiver takes it. Reset clears
// the state machine and the point count; the memories are not cleared and no
// entry is read before it is written in the current set.
`default_nettype none

module point_lexicographic_sorter_unit
  import pls_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pls_in_if.sink     points,
  pls_out_if.source  sorted
);

  localparam int IDX_BITS = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
  localparam int PT_BITS  = 2 * COORD_BITS;

  state_t state;
  state_t state_next;

  logic [CNT_BITS-1:0] count;
  logic [IDX_BITS-1:0] pos;
  logic [IDX_BITS-1:0] cmp_idx;
  logic [IDX_BITS-1:0] last_idx;

  logic signed [COORD_BITS-1:0] key_x;
  logic signed [COORD_BITS-1:0] key_y;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         out_final;
  logic                         out_valid;

  logic                in_ready;
  logic                in_take;
  logic                has_room;
  logic                out_take;
  logic                scan_more;

  logic                st_wr_en;
  logic                st_rd_en;
  logic [IDX_BITS-1:0] st_rd_addr;
  logic [PT_BITS-1:0]  st_rd_data;
  logic                ord_wr_en;
  logic                ord_rd_en;
  logic [PT_BITS-1:0]  ord_rd_data;
  logic [IDX_BITS-1:0] rank;
  rank_ctl_t           rank_ctl;

  assign has_room  = count < CNT_BITS'(MAX_POINTS);
  assign in_take   = points.valid && in_ready;
  assign out_take  = out_valid && sorted.ready;
  assign last_idx  = IDX_BITS'(count - CNT_BITS'(1));
  assign scan_more = (CNT_BITS'(cmp_idx) + CNT_BITS'(1)) < count;

  pls_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (PT_BITS)
  ) u_point_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (IDX_BITS'(count)),
    .wr_data ({points.point_x, points.point_y}),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  pls_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (PT_BITS)
  ) u_order_store (
    .clk     (clk),
    .wr_en   (ord_wr_en),
    .wr_addr (rank),
    .wr_data ({key_x, key_y}),
    .rd_en   (ord_rd_en),
    .rd_addr (pos),
    .rd_data (ord_rd_data)
  );

  pls_rank_unit #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_rank (
    .clk    (clk),
    .rst    (rst),
    .ctl    (rank_ctl),
    .key_x  (key_x),
    .key_y  (key_y),
    .cand_x (st_rd_data[PT_BITS-1:COORD_BITS]),
    .cand_y (st_rd_data[COORD_BITS-1:0]),
    .rank   (rank)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (in_take && points.final_point) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_KEY;
      ST_KEY:   state_next = ST_SCAN;
      ST_SCAN:  if (!scan_more) state_next = ST_PLACE;
      ST_PLACE: state_next = (pos == last_idx) ? ST_RD : ST_FETCH;
      ST_RD:    state_next = ST_LD;
      ST_LD:    state_next = ST_SEND;
      ST_SEND: begin
        if (out_take) state_next = out_final ? ST_LOAD : ST_RD;
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    st_wr_en   = 1'b0;
    st_rd_en   = 1'b0;
    st_rd_addr = pos;
    ord_wr_en  = 1'b0;
    ord_rd_en  = 1'b0;
    rank_ctl   = '{clear: 1'b0, en: 1'b0, earlier: 1'b0};
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        st_wr_en = in_take && has_room;
      end
      ST_FETCH: begin
        st_rd_en       = 1'b1;
        rank_ctl.clear = 1'b1;
      end
      ST_KEY: begin
        st_rd_en   = 1'b1;
        st_rd_addr = '0;
      end
      ST_SCAN: begin
        st_rd_en         = scan_more;
        st_rd_addr       = cmp_idx + IDX_BITS'(1);
        rank_ctl.en      = 1'b1;
        rank_ctl.earlier = cmp_idx < pos;
      end
      ST_PLACE: ord_wr_en = 1'b1;
      ST_RD:    ord_rd_en = 1'b1;
      ST_LD, ST_SEND: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      pos       <= '0;
      cmp_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (in_take && has_room) count <= count + CNT_BITS'(1);
          if (in_take && points.final_point) pos <= '0;
        end
        ST_KEY:  cmp_idx <= '0;
        ST_SCAN: cmp_idx <= cmp_idx + IDX_BITS'(1);
        ST_PLACE: begin
          // The same index register walks the order store during output.
          pos <= (pos == last_idx) ? '0 : pos + IDX_BITS'(1);
        end
        ST_LD: out_valid <= 1'b1;
        ST_SEND: begin
          if (out_take) begin
            out_valid <= 1'b0;
            if (out_final) begin
              count <= '0;
            end else begin
              pos <= pos + IDX_BITS'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_KEY) begin
      key_x <= st_rd_data[PT_BITS-1:COORD_BITS];
      key_y <= st_rd_data[COORD_BITS-1:0];
    end
    if (state == ST_LD) begin
      out_x     <= ord_rd_data[PT_BITS-1:COORD_BITS];
      out_y     <= ord_rd_data[COORD_BITS-1:0];
      out_final <= pos == last_idx;
    end
  end

  assign points.ready        = in_ready;
  assign sorted.valid        = out_valid;
  assign sorted.sorted_x     = out_x;
  assign sorted.sorted_y     = out_y;
  assign sorted.final_result = out_final;

`ifndef NO_ASSERTIONS
  a_valid_in_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_SEND)
    else $error("sorted word shown outside the send state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_POINTS))
    else $error("point count exceeds the store depth");

  a_nonempty_sort: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> count != '0)
    else $error("sort or output running on an empty set");

  a_final_starts: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.ready && points.final_point) |=> state == ST_FETCH)
    else $error("final point did not start the sort");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_final) |=> (state == ST_LOAD && count == '0))
    else $error("set not cleared after the last sorted word");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for point_lexicographic_sorter_unit.
// Point sets are loaded through the input channel and every sorted word is
// compared with the order that a behavioral insertion sort predicts: ascending
// x, ties broken by ascending y, with the last word of each set flagged. A
// short directed table comes first, then random sets with random gaps on both
// channels, a long receiver hold-off, full and over-full stores, and a calm
// stretch without gaps at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pls_pkg::*;

  localparam int CB             = COORD_BITS_DEF;
  localparam int MAXP           = MAX_POINTS_DEF;
  localparam int WATCHDOG_LIMIT = 25000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 40;
  localparam int DIRECTED_ROWS  = 17;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } sorted_word_t;

  // A typed row closes a set of one point; its word is written out by hand.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   fin;
    bit     typed;
    coord_t ex;
    coord_t ey;
  } stim_row_t;

  typedef enum int {
    SPREAD_WIDE,
    SPREAD_TIGHT,
    SPREAD_EDGE,
    SPREAD_MIXED
  } spread_t;

  localparam coord_t COORD_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam coord_t ALT_LOW   = coord_t'(18'h15555);
  localparam coord_t ALT_HIGH  = coord_t'(18'h2AAAA);

  logic clk;
  logic rst;

  pls_in_if  #(.COORD_BITS(CB)) points_ch ();
  pls_out_if #(.COORD_BITS(CB)) sorted_ch ();

  point_lexicographic_sorter_unit #(
    .MAX_POINTS(MAXP),
    .COORD_BITS(CB)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .points(points_ch),
    .sorted(sorted_ch)
  );

  point_t       held_points [MAXP];
  int           held_count = 0;
  sorted_word_t sorted_due [$];
  sorted_word_t want;
  int           mismatches   = 0;
  int           quiet_cycles = 0;
  int           send_odds    = 0;
  int           stall_odds   = 0;
  bit           calm         = 1'b0;
  bit           hold_request = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{coord_t'(0), coord_t'(0),   1'b1, 1'b1, coord_t'(0), coord_t'(0)},
    '{COORD_MAX,   COORD_MIN,     1'b1, 1'b1, COORD_MAX,   COORD_MIN},
    '{COORD_MIN,   COORD_MAX,     1'b1, 1'b1, COORD_MIN,   COORD_MAX},
    '{coord_t'(-1), coord_t'(-1), 1'b1, 1'b1, coord_t'(-1), coord_t'(-1)},
    '{COORD_MAX,   COORD_MAX,     1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{COORD_MIN,   COORD_MIN,     1'b1, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(5), coord_t'(3),   1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(5), coord_t'(-3),  1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(5), coord_t'(3),   1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(-5), coord_t'(100), 1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(5), COORD_MIN,     1'b1, 1'b0, coord_t'(0), coord_t'(0)},
    '{ALT_LOW,     ALT_HIGH,      1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{ALT_HIGH,    ALT_LOW,       1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{ALT_HIGH,    ALT_HIGH,      1'b1, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(0), coord_t'(1),   1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(0), coord_t'(-1),  1'b0, 1'b0, coord_t'(0), coord_t'(0)},
    '{coord_t'(0), coord_t'(0),   1'b1, 1'b0, coord_t'(0), coord_t'(0)}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit comes_first(input point_t a, input point_t b);
    if (a.x != b.x) begin
      return $signed(a.x) < $signed(b.x);
    end
    return $signed(a.y) < $signed(b.y);
  endfunction

  // Tracks the points held for the current set and, on the closing point,
  // queues the whole set in sorted order. Points beyond a full store are lost.
  function automatic void predict_sorted_order(input point_t p, input logic fin,
                                               input bit typed, input point_t typed_exp);
    point_t       order [MAXP];
    point_t       key;
    sorted_word_t w;
    int           n;
    int           i;
    int           j;
    if (held_count < MAXP) begin
      held_points[held_count] = p;
      held_count++;
    end
    if (fin) begin
      n = held_count;
      for (i = 0; i < n; i++) begin
        key = held_points[i];
        j = i;
        while (j > 0 && comes_first(key, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = key;
      end
      if (typed) begin
        w.x    = typed_exp.x;
        w.y    = typed_exp.y;
        w.last = 1'b1;
        sorted_due.push_back(w);
      end else begin
        for (i = 0; i < n; i++) begin
          w.x    = order[i].x;
          w.y    = order[i].y;
          w.last = (i == n - 1);
          sorted_due.push_back(w);
        end
      end
      held_count = 0;
    end
  endfunction

  function automatic coord_t pick_coord(input spread_t s);
    spread_t m;
    m = s;
    if (m == SPREAD_MIXED) begin
      m = spread_t'($urandom_range(0, 2));
    end
    case (m)
      SPREAD_TIGHT: return coord_t'(int'($urandom_range(0, 6)) - 3);
      SPREAD_EDGE: begin
        case ($urandom_range(0, 5))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return coord_t'(0);
          3: return coord_t'(-1);
          4: return COORD_MIN + coord_t'(1);
          default: return COORD_MAX - coord_t'(1);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Presents one point, possibly after a short gap, and returns at the edge
  // where the word is taken.
  task automatic offer_point(input point_t p, input logic fin);
    if (send_odds != 0 && $urandom_range(0, 99) < send_odds) begin
      points_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    points_ch.valid       <= 1'b1;
    points_ch.point_x     <= p.x;
    points_ch.point_y     <= p.y;
    points_ch.final_point <= fin;
    do @(posedge clk); while (points_ch.ready !== 1'b1);
  endtask

  task automatic send_set(input int n, input spread_t s);
    point_t p;
    point_t unused;
    logic   fin;
    int     k;
    unused = '0;
    if (calm) begin
      send_odds  = 0;
      stall_odds = 0;
    end else begin
      case ($urandom_range(0, 2))
        0: send_odds = 0;
        1: send_odds = 15;
        default: send_odds = 45;
      endcase
      case ($urandom_range(0, 2))
        0: stall_odds = 0;
        1: stall_odds = 15;
        default: stall_odds = 45;
      endcase
    end
    for (k = 0; k < n; k++) begin
      p.x = pick_coord(s);
      p.y = pick_coord(s);
      fin = (k == n - 1);
      offer_point(p, fin);
      predict_sorted_order(p, fin, 1'b0, unused);
    end
  endtask

  task automatic run_sets(input int item_goal);
    int sent;
    int n;
    int r;
    sent = 0;
    while (sent < item_goal) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = $urandom_range(1, 8);
      end else if (r < 90) begin
        n = $urandom_range(9, 20);
      end else begin
        n = $urandom_range(21, 40);
      end
      send_set(n, spread_t'($urandom_range(0, 3)));
      sent += n;
    end
  endtask

  // The last point offered must not stay valid, or the block would take it
  // again once it returns to loading.
  task automatic wait_for_sorted();
    points_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random bursts of back-pressure, or one long hold-off on request.
  initial begin
    sorted_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request) begin
        sorted_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
        sorted_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        sorted_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && sorted_ch.valid && sorted_ch.ready) begin
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected sorted word: x=%0d y=%0d last=%0b",
                   sorted_ch.sorted_x, sorted_ch.sorted_y, sorted_ch.final_result);
        end
      end else begin
        want = sorted_due.pop_front();
        if (sorted_ch.sorted_x !== want.x || sorted_ch.sorted_y !== want.y ||
            sorted_ch.final_result !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sorted word mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.x, want.y, want.last,
                     sorted_ch.sorted_x, sorted_ch.sorted_y, sorted_ch.final_result);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (points_ch.valid && points_ch.ready) ||
        (sorted_ch.valid && sorted_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** point_lexicographic_sorter_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    point_t p;
    point_t e;
    int     r;
    points_ch.valid       <= 1'b0;
    points_ch.point_x     <= '0;
    points_ch.point_y     <= '0;
    points_ch.final_point <= 1'b0;
    rst                   <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_odds  = 20;
    stall_odds = 20;
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      p.x = directed_rows[r].x;
      p.y = directed_rows[r].y;
      e.x = directed_rows[r].ex;
      e.y = directed_rows[r].ey;
      offer_point(p, directed_rows[r].fin);
      predict_sorted_order(p, directed_rows[r].fin, directed_rows[r].typed, e);
    end

    run_sets(150);

    // Hold the receiver off while the sender keeps offering sets, so the
    // block stalls its input behind undelivered words.
    wait_for_sorted();
    hold_request = 1'b1;
    repeat (3) send_set(4, SPREAD_MIXED);

    // A store filled exactly, then one overrun so the closing point is lost.
    wait_for_sorted();
    send_set(MAXP, SPREAD_WIDE);
    send_set(MAXP + 4, SPREAD_TIGHT);

    wait_for_sorted();
    run_sets(150);

    wait_for_sorted();
    calm = 1'b1;
    run_sets(60);

    points_ch.valid <= 1'b0;
    wait_for_sorted();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** point_lexicographic_sorter_unit: PASSED **");
    end else begin
      $display("** point_lexicographic_sorter_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
